@@ rtl/sfoc_pkg.sv @@
// shared types, constants and helpers of the state feedback observer controller
// no dependencies; sfoc_ctrl, sfoc_dp and the top level refer to this package by scoped names
package sfoc_pkg;

  localparam int unsigned MaxStates  = 8;
  localparam int unsigned MaxOutputs = 8;
  localparam int unsigned FracBits   = 16;
  localparam int unsigned DataW      = 32;

  localparam int unsigned StW   = $clog2(MaxStates);
  localparam int unsigned OutW  = $clog2(MaxOutputs);
  localparam int unsigned CntW  = 4;
  localparam int unsigned RowW  = 3;
  localparam int unsigned ColW  = 4;
  localparam int unsigned SelW  = 3;
  localparam int unsigned TabAw = 2 + RowW + ColW;
  localparam int unsigned TabDepth = 1 << TabAw;

  // multiplier operand, product, shifted term and accumulator widths
  localparam int unsigned OpW   = DataW + 1;
  localparam int unsigned ProdW = OpW + DataW;
  localparam int unsigned TermW = ProdW - FracBits;
  localparam int unsigned AccW  = TermW + 8;

  localparam logic [ColW-1:0] MtCols = ColW'(MaxOutputs + 1);

  // coefficient memory banks, equal to the low bits of the table selector
  localparam logic [1:0] BankMf = 2'd1;
  localparam logic [1:0] BankMt = 2'd2;
  localparam logic [1:0] BankL  = 2'd3;

  typedef enum logic {REQ_TABLE, REQ_MEAS} req_e;
  typedef enum logic [SelW-1:0] {
    TSEL_GAIN = 3'd0, TSEL_MF = 3'd1, TSEL_MT = 3'd2, TSEL_L = 3'd3, TSEL_REF = 3'd4
  } tsel_e;
  typedef enum logic [1:0] {OBS_NONE = 2'd0, OBS_FULL = 2'd1, OBS_REDUCED = 2'd2} obs_e;
  typedef enum logic {MODE_REGULATOR, MODE_TRACKING} mode_e;
  typedef enum logic [1:0] {CFG_MODE, CFG_OBS, CFG_STATES, CFG_OUTPUTS} cfg_idx_e;
  typedef enum logic [2:0] {TERM_MF, TERM_MT, TERM_MTU, TERM_L, TERM_K} term_e;
  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_OBS, ST_OBS_WAIT, ST_COPY, ST_FILL,
    ST_LCOR, ST_LCOR_WAIT, ST_EFF, ST_EFF_WAIT
  } ctrl_state_e;

  typedef struct packed {
    mode_e            mode;
    obs_e             obs;
    logic [CntW-1:0]  n;
    logic [CntW-1:0]  m;
    logic [CntW-1:0]  q;
    logic [CntW-1:0]  k;
  } cfg_t;

  typedef struct packed {
    logic             valid;
    term_e            kind;
    logic [RowW-1:0]  row;
    logic [ColW-1:0]  col;
    logic [StW-1:0]   dst;
    logic             first;
    logic             last;
  } term_cmd_t;

  typedef struct packed {
    term_cmd_t         term;
    logic              clr_we;
    logic [TabAw-1:0]  clr_addr;
    logic              step_start;
    logic              copy_nv;
    logic              fill_x;
  } dp_cmd_t;

  function automatic logic [CntW-1:0] clamp_cnt(input logic [CntW-1:0] v,
                                                input logic [CntW-1:0] hi);
    logic [CntW-1:0] r;
    if (v == '0) r = CntW'(1);
    else if (v > hi) r = hi;
    else r = v;
    return r;
  endfunction

  // returns {overflow, saturated 32 bit value}
  function automatic logic [DataW:0] sat_acc(input logic signed [AccW-1:0] v);
    logic signed [AccW-1:0] vmax;
    logic signed [AccW-1:0] vmin;
    logic [DataW:0]         r;
    vmax = {{(AccW-DataW+1){1'b0}}, {(DataW-1){1'b1}}};
    vmin = {{(AccW-DataW+1){1'b1}}, {(DataW-1){1'b0}}};
    if (v > vmax) r = {1'b1, 1'b0, {(DataW-1){1'b1}}};
    else if (v < vmin) r = {1'b1, 1'b1, {(DataW-1){1'b0}}};
    else r = {1'b0, v[DataW-1:0]};
    return r;
  endfunction

endpackage

@@ rtl/sfoc_ram.sv @@
// generic single write port ram with registered read
// no dependencies
module sfoc_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 512
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

@@ rtl/sfoc_ctrl.sv @@
// sequencer: clearing pass, term issue for observer, correction and effort phases
// depends on sfoc_pkg
module sfoc_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  sfoc_pkg::cfg_t  cfg_i,
  input  logic            start_i,
  input  logic            out_valid_i,
  input  logic            out_ready_i,
  output logic            in_ready_o,
  output sfoc_pkg::dp_cmd_t cmd_o
);

  sfoc_pkg::ctrl_state_e state_q, state_d;
  logic [sfoc_pkg::CntW-1:0]  i_q, i_d, j_q, j_d;
  sfoc_pkg::term_e            kind_q, kind_d;
  logic [1:0]                 wait_q, wait_d;
  logic [sfoc_pkg::TabAw-1:0] clr_q, clr_d;

  logic [sfoc_pkg::CntW-1:0] obs_rows, i_inc, j_inc;
  logic obs_done, lcor_row_end, lcor_done, eff_done, wait_done, clr_done, reduce_q;

  assign obs_rows     = (cfg_i.obs == sfoc_pkg::OBS_FULL) ? cfg_i.n : cfg_i.q;
  assign i_inc        = i_q + sfoc_pkg::CntW'(1);
  assign j_inc        = j_q + sfoc_pkg::CntW'(1);
  assign obs_done     = (kind_q == sfoc_pkg::TERM_MTU) && (i_inc == obs_rows);
  assign lcor_row_end = (j_inc == cfg_i.m);
  assign lcor_done    = lcor_row_end && (i_inc == cfg_i.q);
  assign eff_done     = (i_inc == cfg_i.n);
  assign wait_done    = (wait_q == 2'd2);
  assign clr_done     = &clr_q;
  assign reduce_q     = (cfg_i.obs == sfoc_pkg::OBS_REDUCED) && (cfg_i.q != '0);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      sfoc_pkg::ST_CLEAR: if (clr_done) state_d = sfoc_pkg::ST_IDLE;
      sfoc_pkg::ST_IDLE: begin
        if (start_i) begin
          if (cfg_i.obs == sfoc_pkg::OBS_FULL || reduce_q) state_d = sfoc_pkg::ST_OBS;
          else state_d = sfoc_pkg::ST_FILL;
        end
      end
      sfoc_pkg::ST_OBS: if (obs_done) state_d = sfoc_pkg::ST_OBS_WAIT;
      sfoc_pkg::ST_OBS_WAIT: if (wait_done) state_d = sfoc_pkg::ST_COPY;
      sfoc_pkg::ST_COPY: begin
        if (cfg_i.obs == sfoc_pkg::OBS_FULL) state_d = sfoc_pkg::ST_EFF;
        else state_d = sfoc_pkg::ST_FILL;
      end
      sfoc_pkg::ST_FILL: begin
        if (reduce_q) state_d = sfoc_pkg::ST_LCOR;
        else state_d = sfoc_pkg::ST_EFF;
      end
      sfoc_pkg::ST_LCOR: if (lcor_done) state_d = sfoc_pkg::ST_LCOR_WAIT;
      sfoc_pkg::ST_LCOR_WAIT: if (wait_done) state_d = sfoc_pkg::ST_EFF;
      sfoc_pkg::ST_EFF: if (eff_done) state_d = sfoc_pkg::ST_EFF_WAIT;
      sfoc_pkg::ST_EFF_WAIT: if (wait_done) state_d = sfoc_pkg::ST_IDLE;
      default: state_d = sfoc_pkg::ST_IDLE;
    endcase
  end

  // loop counters
  always_comb begin
    i_d    = '0;
    j_d    = '0;
    kind_d = sfoc_pkg::TERM_MF;
    wait_d = '0;
    clr_d  = clr_q;
    unique case (state_q)
      sfoc_pkg::ST_CLEAR: clr_d = clr_q + sfoc_pkg::TabAw'(1);
      sfoc_pkg::ST_OBS: begin
        i_d    = i_q;
        j_d    = j_q;
        kind_d = kind_q;
        unique case (kind_q)
          sfoc_pkg::TERM_MF: begin
            if (j_inc < obs_rows) j_d = j_inc;
            else begin
              kind_d = sfoc_pkg::TERM_MT;
              j_d    = '0;
            end
          end
          sfoc_pkg::TERM_MT: begin
            if (j_inc < cfg_i.m) j_d = j_inc;
            else begin
              kind_d = sfoc_pkg::TERM_MTU;
              j_d    = cfg_i.m;
            end
          end
          default: begin
            kind_d = sfoc_pkg::TERM_MF;
            j_d    = '0;
            i_d    = i_inc;
          end
        endcase
      end
      sfoc_pkg::ST_LCOR: begin
        if (lcor_row_end) i_d = i_inc;
        else begin
          i_d = i_q;
          j_d = j_inc;
        end
      end
      sfoc_pkg::ST_EFF: i_d = i_inc;
      sfoc_pkg::ST_OBS_WAIT, sfoc_pkg::ST_LCOR_WAIT, sfoc_pkg::ST_EFF_WAIT:
        wait_d = wait_q + 2'd1;
      default: ;
    endcase
  end

  always_comb begin
    cmd_o            = '0;
    cmd_o.term.row   = i_q[sfoc_pkg::RowW-1:0];
    cmd_o.term.col   = j_q;
    cmd_o.term.dst   = i_q[sfoc_pkg::StW-1:0];
    cmd_o.term.kind  = kind_q;
    cmd_o.clr_addr   = clr_q;
    cmd_o.clr_we     = (state_q == sfoc_pkg::ST_CLEAR);
    cmd_o.step_start = (state_q == sfoc_pkg::ST_IDLE) && start_i;
    cmd_o.copy_nv    = (state_q == sfoc_pkg::ST_COPY);
    cmd_o.fill_x     = (state_q == sfoc_pkg::ST_FILL);
    unique case (state_q)
      sfoc_pkg::ST_OBS: begin
        cmd_o.term.valid = 1'b1;
        cmd_o.term.first = (kind_q == sfoc_pkg::TERM_MF) && (j_q == '0);
        cmd_o.term.last  = (kind_q == sfoc_pkg::TERM_MTU);
      end
      sfoc_pkg::ST_LCOR: begin
        cmd_o.term.valid = 1'b1;
        cmd_o.term.kind  = sfoc_pkg::TERM_L;
        cmd_o.term.dst   = sfoc_pkg::StW'(cfg_i.k + i_q);
        cmd_o.term.first = (j_q == '0);
        cmd_o.term.last  = lcor_row_end;
      end
      sfoc_pkg::ST_EFF: begin
        cmd_o.term.valid = 1'b1;
        cmd_o.term.kind  = sfoc_pkg::TERM_K;
        cmd_o.term.first = (i_q == '0);
        cmd_o.term.last  = eff_done;
      end
      default: ;
    endcase
  end

  assign in_ready_o = (state_q == sfoc_pkg::ST_IDLE) && (!out_valid_i || out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sfoc_pkg::ST_CLEAR;
      i_q     <= '0;
      j_q     <= '0;
      kind_q  <= sfoc_pkg::TERM_MF;
      wait_q  <= '0;
      clr_q   <= '0;
    end else begin
      state_q <= state_d;
      i_q     <= i_d;
      j_q     <= j_d;
      kind_q  <= kind_d;
      wait_q  <= wait_d;
      clr_q   <= clr_d;
    end
  end

endmodule

@@ rtl/sfoc_dp.sv @@
// datapath: vector registers, coefficient ram, three stage multiply-accumulate
// depends on sfoc_pkg and sfoc_ram
module sfoc_dp (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  sfoc_pkg::cfg_t                cfg_i,
  input  sfoc_pkg::dp_cmd_t             cmd_i,
  input  logic                          tab_we_i,
  input  logic                          meas_we_i,
  input  logic [sfoc_pkg::SelW-1:0]     sel_i,
  input  logic [sfoc_pkg::RowW-1:0]     row_i,
  input  logic [sfoc_pkg::ColW-1:0]     col_i,
  input  logic [sfoc_pkg::DataW-1:0]    value_i,
  input  logic                          out_ready_i,
  output logic                          out_valid_o,
  output logic [sfoc_pkg::DataW-1:0]    out_effort_o,
  output logic                          out_sat_o
);

  localparam int unsigned DataW = sfoc_pkg::DataW;
  localparam int unsigned OpW   = sfoc_pkg::OpW;
  localparam int unsigned AccW  = sfoc_pkg::AccW;
  localparam int unsigned StW   = sfoc_pkg::StW;
  localparam int unsigned OutW  = sfoc_pkg::OutW;

  logic [DataW-1:0] gain_q [sfoc_pkg::MaxStates];
  logic [DataW-1:0] ref_q  [sfoc_pkg::MaxStates];
  logic [DataW-1:0] x_q    [sfoc_pkg::MaxStates];
  logic [DataW-1:0] p_q    [sfoc_pkg::MaxStates];
  logic [DataW-1:0] nv_q   [sfoc_pkg::MaxStates];
  logic [DataW-1:0] y_q    [sfoc_pkg::MaxOutputs];
  logic [DataW-1:0] uprev_q;
  logic             sat_q;

  // coefficient memory
  logic                       ram_we;
  logic [sfoc_pkg::TabAw-1:0] ram_waddr, ram_raddr;
  logic [DataW-1:0]           ram_wdata, ram_rdata;
  logic                       tab_ram_ok;

  assign tab_ram_ok = tab_we_i &&
    ((sel_i == sfoc_pkg::TSEL_MF && col_i < sfoc_pkg::ColW'(sfoc_pkg::MaxStates)) ||
     (sel_i == sfoc_pkg::TSEL_MT && col_i < sfoc_pkg::MtCols) ||
     (sel_i == sfoc_pkg::TSEL_L  && col_i < sfoc_pkg::ColW'(sfoc_pkg::MaxOutputs)));
  assign ram_we    = cmd_i.clr_we || tab_ram_ok;
  assign ram_waddr = cmd_i.clr_we ? cmd_i.clr_addr : {sel_i[1:0], row_i, col_i};
  assign ram_wdata = cmd_i.clr_we ? '0 : value_i;

  sfoc_ram #(.Width(DataW), .Depth(sfoc_pkg::TabDepth)) u_coef_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // stage a: address and vector operand
  sfoc_pkg::term_cmd_t t;
  logic [StW-1:0]      xi, ri;
  logic [OutW-1:0]     yi;
  logic signed [OpW-1:0] diff, a_k;
  logic [DataW-1:0]    e_val, b_val;
  logic                e_ovf, use_ram;

  assign t  = cmd_i.term;
  assign xi = t.col[StW-1:0];
  assign yi = t.col[OutW-1:0];
  assign ri = t.row[StW-1:0];

  always_comb begin
    diff  = $signed({ref_q[ri][DataW-1], ref_q[ri]}) - $signed({x_q[ri][DataW-1], x_q[ri]});
    e_ovf = diff[OpW-1] != diff[OpW-2];
    e_val = e_ovf ? {diff[OpW-1], {(DataW-1){~diff[OpW-1]}}} : diff[DataW-1:0];
    a_k   = (cfg_i.mode == sfoc_pkg::MODE_TRACKING) ? $signed({gain_q[ri][DataW-1], gain_q[ri]})
                                                    : -$signed({gain_q[ri][DataW-1], gain_q[ri]});
    ram_raddr = {sfoc_pkg::BankMf, t.row, t.col};
    use_ram   = 1'b1;
    b_val     = y_q[yi];
    unique case (t.kind)
      sfoc_pkg::TERM_MF: begin
        b_val = (cfg_i.obs == sfoc_pkg::OBS_FULL) ? x_q[xi] : p_q[xi];
      end
      sfoc_pkg::TERM_MT: ram_raddr = {sfoc_pkg::BankMt, t.row, t.col};
      sfoc_pkg::TERM_MTU: begin
        ram_raddr = {sfoc_pkg::BankMt, t.row, t.col};
        b_val     = uprev_q;
      end
      sfoc_pkg::TERM_L: ram_raddr = {sfoc_pkg::BankL, t.row, t.col};
      default: begin
        use_ram = 1'b0;
        b_val   = (cfg_i.mode == sfoc_pkg::MODE_TRACKING) ? e_val : x_q[ri];
      end
    endcase
  end

  sfoc_pkg::term_cmd_t   sa_q, sb_q;
  logic                  sa_ram_q;
  logic signed [OpW-1:0] sa_a_q;
  logic [DataW-1:0]      sa_b_q;
  logic signed [sfoc_pkg::ProdW-1:0] prod_q;
  logic signed [AccW-1:0] acc_q, acc_sum, base;
  logic signed [OpW-1:0]  mul_a;
  logic [DataW:0]         sat_res;
  logic                   fin_obs, fin_l, fin_k, e_sat_a;

  assign mul_a = sa_ram_q ? $signed({ram_rdata[DataW-1], ram_rdata}) : sa_a_q;

  // stage c: floor shift, accumulate, saturate at row end
  always_comb begin
    if (!sb_q.first) base = acc_q;
    else if (sb_q.kind == sfoc_pkg::TERM_L)
      base = AccW'($signed(p_q[sb_q.row[StW-1:0]]));
    else base = '0;
    acc_sum = base + AccW'($signed(prod_q[sfoc_pkg::ProdW-1:sfoc_pkg::FracBits]));
    sat_res = sfoc_pkg::sat_acc(acc_sum);
  end

  assign fin_obs = sb_q.valid && sb_q.last &&
                   (sb_q.kind == sfoc_pkg::TERM_MF || sb_q.kind == sfoc_pkg::TERM_MT ||
                    sb_q.kind == sfoc_pkg::TERM_MTU);
  assign fin_l   = sb_q.valid && sb_q.last && (sb_q.kind == sfoc_pkg::TERM_L);
  assign fin_k   = sb_q.valid && sb_q.last && (sb_q.kind == sfoc_pkg::TERM_K);
  assign e_sat_a = t.valid && (t.kind == sfoc_pkg::TERM_K) &&
                   (cfg_i.mode == sfoc_pkg::MODE_TRACKING) && e_ovf;

  always_ff @(posedge clk_i) begin
    sa_ram_q <= use_ram;
    sa_a_q   <= a_k;
    sa_b_q   <= b_val;
    prod_q   <= mul_a * $signed(sa_b_q);
    if (sb_q.valid) acc_q <= acc_sum;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sa_q <= '0;
      sb_q <= '0;
    end else begin
      sa_q <= t;
      sb_q <= sa_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < sfoc_pkg::MaxStates; i++) begin
        gain_q[i] <= '0;
        ref_q[i]  <= '0;
        x_q[i]    <= '0;
        p_q[i]    <= '0;
        nv_q[i]   <= '0;
      end
      for (int i = 0; i < sfoc_pkg::MaxOutputs; i++) y_q[i] <= '0;
      uprev_q      <= '0;
      sat_q        <= 1'b0;
      out_valid_o  <= 1'b0;
      out_effort_o <= '0;
      out_sat_o    <= 1'b0;
    end else begin
      if (tab_we_i && col_i < sfoc_pkg::ColW'(sfoc_pkg::MaxStates)) begin
        if (sel_i == sfoc_pkg::TSEL_GAIN) gain_q[col_i[StW-1:0]] <= value_i;
        if (sel_i == sfoc_pkg::TSEL_REF)  ref_q[col_i[StW-1:0]]  <= value_i;
      end
      if (meas_we_i && col_i < sfoc_pkg::ColW'(sfoc_pkg::MaxOutputs)) begin
        y_q[col_i[OutW-1:0]] <= value_i;
      end
      if (cmd_i.step_start) sat_q <= 1'b0;
      else sat_q <= sat_q | e_sat_a | (sb_q.valid && sb_q.last && sat_res[DataW]);

      if (fin_obs) nv_q[sb_q.row[StW-1:0]] <= sat_res[DataW-1:0];
      if (fin_l)   x_q[sb_q.dst] <= sat_res[DataW-1:0];

      for (int i = 0; i < sfoc_pkg::MaxStates; i++) begin
        if (cmd_i.copy_nv) begin
          if (cfg_i.obs == sfoc_pkg::OBS_FULL) begin
            if (sfoc_pkg::CntW'(i) < cfg_i.n) x_q[i] <= nv_q[i];
          end else if (sfoc_pkg::CntW'(i) < cfg_i.q) begin
            p_q[i] <= nv_q[i];
          end
        end
        if (cmd_i.fill_x) begin
          if (cfg_i.obs == sfoc_pkg::OBS_REDUCED) begin
            if (i < sfoc_pkg::MaxOutputs && sfoc_pkg::CntW'(i) < cfg_i.k)
              x_q[i] <= y_q[OutW'(i)];
          end else if (sfoc_pkg::CntW'(i) < cfg_i.n) begin
            if (i < sfoc_pkg::MaxOutputs && sfoc_pkg::CntW'(i) < cfg_i.m)
              x_q[i] <= y_q[OutW'(i)];
            else x_q[i] <= '0;
          end
        end
      end

      if (fin_k) begin
        out_valid_o  <= 1'b1;
        out_effort_o <= sat_res[DataW-1:0];
        out_sat_o    <= sat_q | sat_res[DataW];
        uprev_q      <= sat_res[DataW-1:0];
      end else if (out_ready_i) begin
        out_valid_o <= 1'b0;
      end
    end
  end

endmodule

@@ rtl/state_feedback_observer_controller.sv @@
// top level of the state feedback controller with selectable observer
// depends on sfoc_pkg, sfoc_ctrl, sfoc_dp (which holds sfoc_ram)
//
// Each input transaction either writes one word of a coefficient table
// (gain row, observer state matrix, observer input matrix, correction
// matrix, reference) or stores one measurement; a measurement with tlast
// set runs one control step and yields one result transaction with the
// Q16.16 effort and a flag telling whether any sum saturated. A single
// shared multiply-accumulate unit works through the step one product per
// cycle, rows*(rows+m+1) + q*m + n products in all. A pipeline drain
// follows each phase, and the observer result is copied and the estimate
// filled where those are used; rows is n for the full observer and
// q = n-min(m,n) for the reduced one. After reset the block sweeps the 512
// word coefficient memory to zero and accepts no input until the sweep is
// done; configuration writes are taken at any time but must only be
// issued while the block is idle.
module state_feedback_observer_controller (
  input  logic        clk_i,
  input  logic        rst_ni,
  // config write channel
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [3:0]  cfg_data_i,
  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // row[2:0], col[6:3], value[38:7], zero[39]
  input  logic [3:0]  s_axis_tuser,   // req_type[0], table_sel[3:1]
  input  logic        s_axis_tlast,   // last_meas
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // control_effort[31:0]
  output logic [0:0]  m_axis_tuser    // saturated[0]
);

  // configuration registers
  logic                      mode_q;
  logic [1:0]                obs_q;
  logic [sfoc_pkg::CntW-1:0] nst_q, nout_q;
  logic                      cfg_we;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 1'b0;
      obs_q  <= 2'd0;
      nst_q  <= sfoc_pkg::CntW'(4);
      nout_q <= sfoc_pkg::CntW'(2);
    end else if (cfg_we) begin
      unique case (cfg_index_i)
        sfoc_pkg::CFG_MODE:    mode_q <= cfg_data_i[0];
        sfoc_pkg::CFG_OBS:     obs_q  <= cfg_data_i[1:0];
        sfoc_pkg::CFG_STATES:  nst_q  <= cfg_data_i;
        sfoc_pkg::CFG_OUTPUTS: nout_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // clamped counts and the split between measured and reduced states
  sfoc_pkg::cfg_t cfg;
  always_comb begin
    cfg.mode = sfoc_pkg::mode_e'(mode_q);
    unique case (obs_q)
      sfoc_pkg::OBS_FULL:    cfg.obs = sfoc_pkg::OBS_FULL;
      sfoc_pkg::OBS_REDUCED: cfg.obs = sfoc_pkg::OBS_REDUCED;
      default: cfg.obs = sfoc_pkg::OBS_NONE;   // unused code acts as no observer
    endcase
    cfg.n = sfoc_pkg::clamp_cnt(nst_q, sfoc_pkg::CntW'(sfoc_pkg::MaxStates));
    cfg.m = sfoc_pkg::clamp_cnt(nout_q, sfoc_pkg::CntW'(sfoc_pkg::MaxOutputs));
    cfg.k = (cfg.m < cfg.n) ? cfg.m : cfg.n;
    cfg.q = cfg.n - cfg.k;
  end

  // input transaction decode
  logic in_accept, tab_we, meas_we, start;
  logic out_valid;
  sfoc_pkg::dp_cmd_t cmd;

  assign in_accept = s_axis_tvalid && s_axis_tready;
  assign tab_we    = in_accept && (s_axis_tuser[0] == sfoc_pkg::REQ_TABLE);
  assign meas_we   = in_accept && (s_axis_tuser[0] == sfoc_pkg::REQ_MEAS);
  assign start     = meas_we && s_axis_tlast;

  sfoc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .start_i     (start),
    .out_valid_i (out_valid),
    .out_ready_i (m_axis_tready),
    .in_ready_o  (s_axis_tready),
    .cmd_o       (cmd)
  );

  sfoc_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .cmd_i        (cmd),
    .tab_we_i     (tab_we),
    .meas_we_i    (meas_we),
    .sel_i        (s_axis_tuser[3:1]),
    .row_i        (s_axis_tdata[2:0]),
    .col_i        (s_axis_tdata[6:3]),
    .value_i      (s_axis_tdata[38:7]),
    .out_ready_i  (m_axis_tready),
    .out_valid_o  (out_valid),
    .out_effort_o (m_axis_tdata),
    .out_sat_o    (m_axis_tuser[0])
  );

  assign m_axis_tvalid = out_valid;

endmodule

@@ tb/state_feedback_observer_controller_tb.sv @@
`timescale 1ns / 100ps
// self-checking testbench of the state feedback observer controller
// depends on sfoc_pkg and the block; it predicts each effort in its own model
module state_feedback_observer_controller_tb;
  import sfoc_pkg::*;

  localparam int unsigned MtWidth = MaxOutputs + 1;
  localparam int unsigned IdleLimit = 20000;

  typedef struct {
    req_e                kind;
    tsel_e               sel;
    logic [2:0]          row;
    logic [3:0]          col;
    logic signed [31:0]  value;
    logic                last;
    logic                has_exp;
    logic signed [31:0]  exp_effort;
    logic                exp_sat;
  } stim_t;

  typedef struct {
    logic signed [31:0] effort;
    logic               sat;
  } effort_t;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i;
  logic [3:0]  cfg_data_i;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata;
  logic [3:0]  s_axis_tuser;
  logic        s_axis_tlast;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [31:0] m_axis_tdata;
  logic [0:0]  m_axis_tuser;

  state_feedback_observer_controller dut (.*);

  // model copy of the coefficient tables, estimates and registers
  logic signed [31:0] k_gain [MaxStates];
  logic signed [31:0] mf_tab [MaxStates][MaxStates];
  logic signed [31:0] mt_tab [MaxStates][MtWidth];
  logic signed [31:0] l_tab  [MaxStates][MaxOutputs];
  logic signed [31:0] ref_vec [MaxStates];
  logic signed [31:0] x_est [MaxStates];
  logic signed [31:0] xo_est [MaxStates];
  logic signed [31:0] y_meas [MaxOutputs];
  logic signed [31:0] u_prev;
  logic [0:0] mode_reg;
  logic [1:0] obs_reg;
  logic [3:0] n_reg;
  logic [3:0] m_reg;
  logic       step_sat;

  effort_t pending_efforts [$];
  int  errors;
  int  idle_cycles = 0;
  bit  rx_idle_on;
  bit  tx_idle_on;
  bit  rx_hold;

  // clock and single reset at the start
  initial clk_i = 1'b0;
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  function automatic logic signed [63:0] qmul(input logic signed [63:0] a,
                                              input logic signed [63:0] b);
    logic signed [127:0] p;
    p = a * b;
    return 64'(p >>> FracBits);  // arithmetic shift rounds toward minus infinity
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) begin
      step_sat = 1'b1;
      return 32'sh7fffffff;
    end
    if (v < -64'sd2147483648) begin
      step_sat = 1'b1;
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

  // new-value update of an estimate vector through Mf and Mt
  task automatic observe(ref logic signed [31:0] v [MaxStates], input int rows, input int m);
    logic signed [31:0] nv [MaxStates];
    logic signed [63:0] acc;
    for (int i = 0; i < rows; i++) begin
      acc = 0;
      for (int j = 0; j < rows; j++) acc += qmul(mf_tab[i][j], v[j]);
      for (int j = 0; j < m; j++) acc += qmul(mt_tab[i][j], y_meas[j]);
      acc += qmul(mt_tab[i][m], u_prev);
      nv[i] = sat32(acc);
    end
    for (int i = 0; i < rows; i++) v[i] = nv[i];
  endtask

  task automatic predict_effort(output effort_t r);
    int n, m, kk, q;
    logic signed [63:0] acc;
    logic signed [31:0] e;
    n = (n_reg == 0) ? 1 : (n_reg > MaxStates) ? MaxStates : n_reg;
    m = (m_reg == 0) ? 1 : (m_reg > MaxOutputs) ? MaxOutputs : m_reg;
    step_sat = 1'b0;
    if (obs_reg == OBS_FULL) begin
      observe(x_est, n, m);
    end else if (obs_reg == OBS_REDUCED) begin
      kk = (m < n) ? m : n;
      q = n - kk;
      observe(xo_est, q, m);
      for (int i = 0; i < kk; i++) x_est[i] = y_meas[i];
      for (int i = 0; i < q; i++) begin
        acc = xo_est[i];
        for (int j = 0; j < m; j++) acc += qmul(l_tab[i][j], y_meas[j]);
        x_est[kk + i] = sat32(acc);
      end
    end else begin
      for (int i = 0; i < n; i++) x_est[i] = (i < m) ? y_meas[i] : 32'sd0;
    end
    acc = 0;
    for (int i = 0; i < n; i++) begin
      if (mode_reg == MODE_REGULATOR) begin
        acc += qmul(-64'(k_gain[i]), x_est[i]);
      end else begin
        e = sat32(64'(ref_vec[i]) - 64'(x_est[i]));
        acc += qmul(k_gain[i], e);
      end
    end
    r.effort = sat32(acc);
    r.sat = step_sat;
    u_prev = r.effort;
  endtask

  // applies one accepted input item to the model; true when a result follows
  task automatic apply_item(input stim_t s, output bit has_result, output effort_t r);
    has_result = 1'b0;
    if (s.kind == REQ_TABLE) begin
      case (s.sel)
        TSEL_GAIN: if (s.col < MaxStates) k_gain[s.col] = s.value;
        TSEL_MF:   if (s.col < MaxStates) mf_tab[s.row][s.col] = s.value;
        TSEL_MT:   if (s.col < MtWidth) mt_tab[s.row][s.col] = s.value;
        TSEL_L:    if (s.col < MaxOutputs) l_tab[s.row][s.col] = s.value;
        TSEL_REF:  if (s.col < MaxStates) ref_vec[s.col] = s.value;
        default: ;
      endcase
    end else begin
      if (s.col < MaxOutputs) y_meas[s.col] = s.value;
      if (s.last) begin
        predict_effort(r);
        has_result = 1'b1;
      end
    end
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [3:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      CFG_MODE:    mode_reg = val[0];
      CFG_OBS:     obs_reg = val[1:0];
      CFG_STATES:  n_reg = val;
      CFG_OUTPUTS: m_reg = val;
    endcase
  endtask

  // sends one item, idling at random before it; checks typed expectations
  task automatic send_item(input stim_t s);
    bit      has_result;
    effort_t r;
    while (tx_idle_on && $urandom_range(99) < 31) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {1'b0, s.value, s.col, s.row};
    s_axis_tuser  <= {s.sel, s.kind};
    s_axis_tlast  <= s.last;
    do @(posedge clk_i); while (!s_axis_tready);
    apply_item(s, has_result, r);
    if (has_result) begin
      if (s.has_exp && (r.effort !== s.exp_effort || r.sat !== s.exp_sat)) begin
        $display("%0t predictor disagrees with table: expected %h/%b actual %h/%b",
                 $time, s.exp_effort, s.exp_sat, r.effort, r.sat);
        errors++;
      end
      pending_efforts.push_back(r);
    end
  endtask

  // waits until every result is back, then lets the step pipeline drain
  task automatic drain;
    s_axis_tvalid <= 1'b0;
    while (pending_efforts.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
  endtask

  function automatic stim_t mk(input req_e kind, input tsel_e sel, input int row,
                               input int col, input logic signed [31:0] value,
                               input bit last);
    stim_t s;
    s.kind = kind;
    s.sel = sel;
    s.row = 3'(row);
    s.col = 4'(col);
    s.value = value;
    s.last = last;
    s.has_exp = 1'b0;
    s.exp_effort = 0;
    s.exp_sat = 1'b0;
    return s;
  endfunction

  function automatic stim_t mk_exp(input stim_t s, input logic signed [31:0] eff,
                                   input bit sat);
    s.has_exp = 1'b1;
    s.exp_effort = eff;
    s.exp_sat = sat;
    return s;
  endfunction

  function automatic logic signed [31:0] rnd_value();
    case ($urandom_range(5))
      0: return $urandom;
      1: return 32'sh7fffffff;
      2: return 32'sh80000000;
      default: return $signed(32'($urandom_range(262143))) - 32'sd131072;
    endcase
  endfunction

  // well-formed table write, occasionally out of range or with an unused selector
  function automatic stim_t rnd_table();
    stim_t s;
    s = mk(REQ_TABLE, tsel_e'($urandom_range(4)), $urandom_range(7),
           $urandom_range(8), rnd_value(), $urandom_range(9) == 0);
    if ($urandom_range(19) == 0) s.sel = tsel_e'($urandom_range(7, 5));
    if ($urandom_range(19) == 0) s.col = 4'($urandom_range(15));
    return s;
  endfunction

  stim_t directed [$];

  // result side: random stalls, one long hold-off, compare against oldest expectation
  initial begin
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) begin
        if (pending_efforts.size() == 0) begin
          $display("%0t unexpected result: effort %h sat %b", $time, m_axis_tdata,
                   m_axis_tuser);
          errors++;
        end else begin
          if (m_axis_tdata !== pending_efforts[0].effort) begin
            $display("%0t effort mismatch: expected %h actual %h", $time,
                     pending_efforts[0].effort, m_axis_tdata);
            errors++;
          end
          if (m_axis_tuser[0] !== pending_efforts[0].sat) begin
            $display("%0t saturated mismatch: expected %b actual %b", $time,
                     pending_efforts[0].sat, m_axis_tuser[0]);
            errors++;
          end
          void'(pending_efforts.pop_front());
        end
      end
      m_axis_tready <= !rx_hold && !(rx_idle_on && $urandom_range(99) < 31);
    end
  end

  // watchdog on cycles with no transaction on any channel
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o) || !rst_ni)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > IdleLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    int n_steps;
    errors = 0;
    rx_idle_on = 1'b1;
    tx_idle_on = 1'b1;
    rx_hold = 1'b0;
    rst_ni = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = '0;
    s_axis_tlast = 1'b0;
    foreach (k_gain[i]) begin
      k_gain[i] = 0;
      ref_vec[i] = 0;
      x_est[i] = 0;
      xo_est[i] = 0;
      foreach (mf_tab[i][j]) mf_tab[i][j] = 0;
      foreach (mt_tab[i][j]) mt_tab[i][j] = 0;
      foreach (l_tab[i][j]) l_tab[i][j] = 0;
    end
    foreach (y_meas[i]) y_meas[i] = 0;
    u_prev = 0;
    mode_reg = MODE_REGULATOR;
    obs_reg = OBS_NONE;
    n_reg = 4;
    m_reg = 2;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed table, reset configuration: regulator, no observer, n 4, m 2
    // zero gains after reset give a zero effort
    directed.push_back(mk_exp(mk(REQ_MEAS, TSEL_GAIN, 0, 0, 32'sh7fffffff, 1), 0, 0));
    // gain 1.0 on state 0, y0 = 2.0 gives -2.0
    directed.push_back(mk(REQ_TABLE, TSEL_GAIN, 5, 0, 32'sh00010000, 0));
    directed.push_back(mk_exp(mk(REQ_MEAS, TSEL_GAIN, 0, 0, 32'sh00020000, 1),
                              32'shfffe0000, 0));
    // y0 at the negative extreme: -(-2^31) overflows to the positive limit
    directed.push_back(mk_exp(mk(REQ_MEAS, TSEL_GAIN, 0, 0, 32'sh80000000, 1),
                              32'sh7fffffff, 1));
    // extreme gain times extreme measurement saturates low
    directed.push_back(mk(REQ_TABLE, TSEL_GAIN, 0, 0, 32'sh7fffffff, 0));
    directed.push_back(mk_exp(mk(REQ_MEAS, TSEL_GAIN, 0, 0, 32'sh7fffffff, 1),
                              32'sh80000000, 1));
    // measurement index beyond the buffer is dropped but the step still runs
    directed.push_back(mk(REQ_TABLE, TSEL_GAIN, 0, 0, 32'sh00010000, 0));
    directed.push_back(mk(REQ_MEAS, TSEL_GAIN, 0, 0, 32'sh00030000, 0));
    directed.push_back(mk_exp(mk(REQ_MEAS, TSEL_GAIN, 0, 15, 32'sh12345678, 1),
                              32'shfffd0000, 0));
    // table write with tlast set yields nothing; unused selector and bad column ignored
    directed.push_back(mk(REQ_TABLE, TSEL_REF, 0, 1, 32'sh00040000, 1));
    directed.push_back(mk(REQ_TABLE, tsel_e'(3'd7), 7, 15, 32'shffffffff, 0));
    directed.push_back(mk(REQ_TABLE, TSEL_GAIN, 0, 8, 32'sh7fffffff, 0));
    directed.push_back(mk(REQ_TABLE, TSEL_MF, 7, 7, 32'sh00008000, 0));
    directed.push_back(mk(REQ_TABLE, TSEL_MT, 7, 8, 32'sh00010000, 0));
    directed.push_back(mk(REQ_TABLE, TSEL_MT, 7, 9, 32'sh7fffffff, 0));
    directed.push_back(mk(REQ_TABLE, TSEL_L, 7, 7, 32'shffff0000, 0));
    directed.push_back(mk(REQ_TABLE, TSEL_L, 7, 8, 32'sh7fffffff, 0));
    directed.push_back(mk(REQ_TABLE, tsel_e'(3'd5), 0, 0, 32'sh0, 1));
    // gain on an unmeasured state sees a zero estimate
    directed.push_back(mk(REQ_TABLE, TSEL_GAIN, 0, 3, 32'sh00050000, 0));
    directed.push_back(mk_exp(mk(REQ_MEAS, TSEL_GAIN, 0, 1, 32'sh00000000, 1),
                              32'shfffd0000, 0));
    foreach (directed[i]) send_item(directed[i]);
    drain();

    // random phases over a sweep of settings; the first phase stresses backpressure
    for (int ph = 0; ph < 12; ph++) begin
      logic [3:0] nv, mv;
      if (ph == 0) begin
        nv = 8;
        mv = 8;
      end else if (ph == 1) begin
        nv = 1;
        mv = 1;
      end else if (ph == 2) begin
        nv = 0;
        mv = 15;
      end else if (ph == 3) begin
        nv = 15;
        mv = 0;
      end else begin
        nv = $urandom_range(15);
        mv = $urandom_range(15);
      end
      write_reg(CFG_MODE, 4'($urandom_range(1)));
      write_reg(CFG_OBS, (ph < 3) ? 4'(ph) : 4'($urandom_range(3)));
      write_reg(CFG_STATES, nv);
      write_reg(CFG_OUTPUTS, mv);
      rx_idle_on = (ph != 5);
      tx_idle_on = (ph != 5);
      if (ph == 0) begin
        fork
          begin
            rx_hold = 1'b1;
            repeat (3000) @(posedge clk_i);
            rx_hold = 1'b0;
          end
        join_none
      end
      // loads a random table chunk then a measurement sample ending in tlast
      n_steps = 0;
      while (n_steps < 9) begin
        int cnt;
        cnt = $urandom_range(10);
        for (int t = 0; t < cnt; t++) send_item(rnd_table());
        cnt = $urandom_range(8, 1);
        for (int t = 0; t < cnt; t++) begin
          stim_t s;
          s = mk(REQ_MEAS, TSEL_GAIN, $urandom_range(7), t, rnd_value(), t == cnt - 1);
          s.sel = tsel_e'($urandom_range(7));
          if ($urandom_range(15) == 0) s.col = 4'($urandom_range(15));
          send_item(s);
        end
        n_steps++;
      end
      drain();
    end

    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
